>>> src/decayed_session_rate_gradient_top_assert.svh
// Assertion macros shared by the decayed session rate gradient RTL.
`ifndef DECAYED_SESSION_RATE_GRADIENT_TOP_ASSERT_SVH
`define DECAYED_SESSION_RATE_GRADIENT_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define DSRG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define DSRG_ASSERT_IMP(lbl, ante, cons, msg) \
  `DSRG_ASSERT(lbl, (ante) |-> (cons), msg)
`else
`define DSRG_ASSERT(lbl, prop, msg)
`define DSRG_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

>>> src/dsrg_pkg.sv
// Types and constants of the decayed session rate gradient block.
`timescale 1ns / 1ps
package dsrg_pkg;

  localparam int PROJECTS  = 256;
  localparam int MAX_DIM   = 16;
  localparam int ROW_W     = $clog2(PROJECTS);
  localparam int DIM_W     = $clog2(MAX_DIM);
  localparam int DIMS_W    = $clog2(MAX_DIM + 1);
  localparam int EMB_W     = ROW_W + DIM_W;
  localparam int EMB_DEPTH = PROJECTS * MAX_DIM;

  localparam int SUM_W = 48;
  localparam int DEN_W = SUM_W + 3;
  localparam int REM_W = DEN_W + 1;
  localparam int Q_W   = 32;
  localparam int CNT_W = $clog2(Q_W + 1);

  localparam logic [SUM_W-1:0] SUM_LIMIT = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] TEN_Q16   = SUM_W'(10 << 16);

  typedef enum logic [1:0] {
    OP_SESSION  = 2'd0,
    OP_LOAD_INT = 2'd1,
    OP_LOAD_EMB = 2'd2,
    OP_RESTART  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CFG_OWN     = 3'd0,
    CFG_DECAY   = 3'd1,
    CFG_FOREIGN = 3'd2,
    CFG_GRAD    = 3'd3,
    CFG_DIMS    = 3'd4
  } cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD,
    ST_DIV,
    ST_WAIT,
    ST_EMIT,
    ST_GRD
  } state_e;

  typedef struct packed {
    logic accept;
    logic mul;
    logic upd;
    logic div_go;
    logic grad_sel;
    logic emit;
    logic j_clr;
    logic j_inc;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic grad_en;
    logic last_dim;
    logic out_free;
  } sts_t;

endpackage

>>> src/dsrg_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module dsrg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/dsrg_div.sv
// Radix-2 restoring divider: saturated (|num| << 16) / (5 * den), signed Q16.16 result.
`timescale 1ns / 1ps
module dsrg_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [dsrg_pkg::SUM_W-1:0] num_i,
  input  logic [dsrg_pkg::SUM_W-1:0]        den_i,
  output logic                              done_o,
  output logic [dsrg_pkg::Q_W-1:0]          quo_o
);

  localparam int SW = dsrg_pkg::SUM_W;
  localparam int DW = dsrg_pkg::DEN_W;
  localparam int RW = dsrg_pkg::REM_W;
  localparam int QW = dsrg_pkg::Q_W;
  localparam int CW = dsrg_pkg::CNT_W;
  localparam logic [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};

  logic          neg_q, zero_q, sat_q, prep_q, done_q;
  logic [SW-1:0] mag_q;
  logic [DW-1:0] den_q;
  logic [RW-1:0] rem_q, rem_sh, rem_d;
  logic [QW-1:0] low_q, quo_q;
  logic [CW-1:0] cnt_q;
  logic          ge;

  assign rem_sh = {rem_q[RW-2:0], low_q[QW-1]};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign rem_d  = ge ? rem_sh - {1'b0, den_q} : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        prep_q <= 1'b1;
      end else if (prep_q) begin
        prep_q <= 1'b0;
        cnt_q  <= CW'(QW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[SW-1];
      mag_q <= num_i[SW-1] ? SW'(-num_i) : num_i;
      den_q <= {3'b000, den_i} + {1'b0, den_i, 2'b00};
    end else if (prep_q) begin
      zero_q <= (mag_q == '0);
      sat_q  <= {{(DW+QW-SW-16){1'b0}}, mag_q, 16'd0} >= {den_q, {QW{1'b0}}};
      rem_q  <= RW'(mag_q[SW-1:16]);
      low_q  <= {mag_q[15:0], {(QW-16){1'b0}}};
      quo_q  <= '0;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      low_q <= {low_q[QW-2:0], 1'b0};
      quo_q <= {quo_q[QW-2:0], ge};
    end
  end

  always_comb begin
    if (zero_q) begin
      quo_o = '0;
    end else if (sat_q) begin
      quo_o = neg_q ? Q_MIN : Q_MAX;
    end else if (neg_q) begin
      quo_o = (quo_q > Q_MIN) ? Q_MIN : QW'(-quo_q);
    end else begin
      quo_o = quo_q[QW-1] ? Q_MAX : quo_q;
    end
  end

  assign done_o = done_q;

endmodule

>>> src/dsrg_datapath.sv
// Datapath: configuration, tables, decayed sums, shared divider and output register.
`timescale 1ns / 1ps
module dsrg_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dsrg_pkg::cmd_t      cmd_i,
  output dsrg_pkg::sts_t      sts_o,
  input  logic [1:0]          opcode_i,
  input  logic [7:0]          project_index_i,
  input  logic [3:0]          element_index_i,
  input  logic signed [31:0]  load_value_i,
  input  logic [15:0]         task_count_i,
  input  logic                cfg_valid_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [16:0]         cfg_data_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic signed [31:0]  rate_o,
  output logic                has_gradient_o,
  output logic [3:0]          gradient_index_o,
  output logic signed [31:0]  gradient_o,
  output logic                last_o
);

  localparam int SW  = dsrg_pkg::SUM_W;
  localparam int TW  = 58;
  localparam int RW  = dsrg_pkg::ROW_W;
  localparam int JW  = dsrg_pkg::DIM_W;
  localparam int NW  = dsrg_pkg::DIMS_W;
  localparam int MD  = dsrg_pkg::MAX_DIM;
  localparam logic signed [TW-1:0] LIM_P = $signed({{(TW-SW){1'b0}}, dsrg_pkg::SUM_LIMIT});
  localparam logic signed [TW-1:0] LIM_N = -LIM_P;

  function automatic logic signed [SW-1:0] clamp_sum(input logic signed [TW-1:0] v);
    logic signed [SW-1:0] r;
    if (v > LIM_P) begin
      r = LIM_P[SW-1:0];
    end else if (v < LIM_N) begin
      r = LIM_N[SW-1:0];
    end else begin
      r = v[SW-1:0];
    end
    return r;
  endfunction

  // configuration
  logic [7:0]  own_q;
  logic [16:0] decay_q;
  logic [15:0] foreign_q;
  logic        gen_q;
  logic [4:0]  dims_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q     <= '0;
      decay_q   <= 17'd65536;
      foreign_q <= 16'd256;
      gen_q     <= 1'b0;
      dims_q    <= 5'd16;
    end else if (cfg_valid_i) begin
      case (dsrg_pkg::cfg_e'(cfg_index_i))
        dsrg_pkg::CFG_OWN:     own_q     <= cfg_data_i[7:0];
        dsrg_pkg::CFG_DECAY:   decay_q   <= cfg_data_i;
        dsrg_pkg::CFG_FOREIGN: foreign_q <= cfg_data_i[15:0];
        dsrg_pkg::CFG_GRAD:    gen_q     <= cfg_data_i[0];
        dsrg_pkg::CFG_DIMS:    dims_q    <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  logic [16:0]   fac;
  logic [NW-1:0] dims_eff;

  assign fac = (decay_q > 17'd65536) ? 17'd65536 : decay_q;

  always_comb begin
    if (dims_q == '0) begin
      dims_eff = NW'(1);
    end else if (32'(dims_q) > MD) begin
      dims_eff = NW'(MD);
    end else begin
      dims_eff = NW'(dims_q);
    end
  end

  // tables
  logic          in_fire;
  logic [RW-1:0] row_in, row_q;
  logic [JW-1:0] j_q;
  logic [31:0]   int_rd, emb_rd;
  logic          int_we, emb_we, rst_sums;

  assign in_fire  = cmd_i.accept;
  assign row_in   = RW'(project_index_i);
  assign int_we   = in_fire && (opcode_i == dsrg_pkg::OP_LOAD_INT);
  assign emb_we   = in_fire && (opcode_i == dsrg_pkg::OP_LOAD_EMB) &&
                    (32'(element_index_i) < MD);
  assign rst_sums = in_fire && (opcode_i == dsrg_pkg::OP_RESTART);

  dsrg_ram #(
    .WIDTH (32),
    .DEPTH (dsrg_pkg::PROJECTS)
  ) u_int_ram (
    .clk_i   (clk_i),
    .we_i    (int_we),
    .waddr_i (row_in),
    .wdata_i (load_value_i),
    .raddr_i (row_in),
    .rdata_o (int_rd)
  );

  dsrg_ram #(
    .WIDTH (32),
    .DEPTH (dsrg_pkg::EMB_DEPTH)
  ) u_emb_ram (
    .clk_i   (clk_i),
    .we_i    (emb_we),
    .waddr_i ({row_in, JW'(element_index_i)}),
    .wdata_i (load_value_i),
    .raddr_i ({row_q, j_q}),
    .rdata_o (emb_rd)
  );

  // session operands
  logic [15:0] w_in, w_q;
  logic [31:0] wt_q;

  assign w_in = (project_index_i == own_q) ? 16'd256 : foreign_q;

  always_ff @(posedge clk_i) begin
    if (in_fire && (opcode_i == dsrg_pkg::OP_SESSION)) begin
      row_q <= row_in;
      w_q   <= w_in;
      wt_q  <= {16'd0, w_in} * {16'd0, task_count_i};
    end
  end

  // sums
  logic signed [SW-1:0] wsum_q, g_q [MD];
  logic [SW-1:0]        wtsum_q;

  // products
  logic signed [31:0]   val;
  logic signed [SW-1:0] src;
  logic [31:0]          vmag;
  logic [SW-1:0]        smag;
  logic                 tneg_q, sneg_q;
  logic [63:0]          prod_q, dprod_q, wprod_q;

  assign val  = cmd_i.grad_sel ? $signed(emb_rd) : $signed(int_rd);
  assign src  = cmd_i.grad_sel ? g_q[j_q] : wsum_q;
  assign vmag = val[31] ? 32'(-val) : val;
  assign smag = src[SW-1] ? SW'(-src) : src;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      tneg_q  <= val[31];
      sneg_q  <= src[SW-1];
      prod_q  <= {32'd0, wt_q} * {32'd0, vmag};
      dprod_q <= {{(64-SW){1'b0}}, smag} * {47'd0, fac};
      wprod_q <= {{(64-SW){1'b0}}, wtsum_q} * {47'd0, fac};
    end
  end

  logic signed [TW-1:0] dec_s, term_s, tot_s;
  logic [SW:0]          ws_sum;
  logic [SW-1:0]        ws_new;

  always_comb begin
    dec_s  = $signed({{(TW-SW){1'b0}}, dprod_q[63:16]});
    term_s = $signed({{(TW-56){1'b0}}, prod_q[63:8]});
    if (sneg_q) begin
      dec_s = -dec_s;
    end
    if (tneg_q) begin
      term_s = -term_s;
    end
    tot_s  = dec_s + term_s;
    ws_sum = {1'b0, dprod_q[63:16] & '0} + {1'b0, wprod_q[63:16]} +
             {{(SW-23){1'b0}}, w_q, 8'd0};
    ws_new = (ws_sum > {1'b0, dsrg_pkg::SUM_LIMIT}) ? dsrg_pkg::SUM_LIMIT : ws_sum[SW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wsum_q  <= $signed(dsrg_pkg::TEN_Q16);
      wtsum_q <= dsrg_pkg::TEN_Q16;
      for (int i = 0; i < MD; i++) begin
        g_q[i] <= '0;
      end
    end else if (rst_sums) begin
      wsum_q  <= $signed(dsrg_pkg::TEN_Q16);
      wtsum_q <= dsrg_pkg::TEN_Q16;
      for (int i = 0; i < MD; i++) begin
        g_q[i] <= '0;
      end
    end else if (cmd_i.upd) begin
      if (cmd_i.grad_sel) begin
        g_q[j_q] <= clamp_sum(tot_s);
      end else begin
        wsum_q  <= clamp_sum(tot_s);
        wtsum_q <= ws_new;
      end
    end
  end

  // dimension counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_q <= '0;
    end else if (cmd_i.j_clr) begin
      j_q <= '0;
    end else if (cmd_i.j_inc) begin
      j_q <= j_q + JW'(1);
    end
  end

  // divider
  logic        div_done;
  logic [31:0] quo;
  logic [31:0] rate_q, grad_q;

  dsrg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_go),
    .num_i   (src),
    .den_i   (wtsum_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_ff @(posedge clk_i) begin
    if (div_done) begin
      if (cmd_i.grad_sel) begin
        grad_q <= quo;
      end else begin
        rate_q <= quo;
      end
    end
  end

  // output register
  logic out_valid_q, last_dim;

  assign last_dim = (NW'(j_q) == dims_eff - NW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      rate_o           <= rate_q;
      has_gradient_o   <= cmd_i.grad_sel;
      gradient_index_o <= cmd_i.grad_sel ? 4'(j_q) : 4'd0;
      gradient_o       <= cmd_i.grad_sel ? grad_q : 32'd0;
      last_o           <= !cmd_i.grad_sel || last_dim;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sts_o.div_done  = div_done;
  assign sts_o.grad_en   = gen_q;
  assign sts_o.last_dim  = last_dim;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

>>> src/dsrg_ctrl.sv
// Controller: sequences sum update, divide and result beats of each session.
`timescale 1ns / 1ps
`include "decayed_session_rate_gradient_top_assert.svh"
module dsrg_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [1:0]     opcode_i,
  output logic           in_ready_o,
  input  dsrg_pkg::sts_t sts_i,
  output dsrg_pkg::cmd_t cmd_o
);

  dsrg_pkg::state_e state_q, state_d;
  logic             gph_q, gph_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dsrg_pkg::ST_IDLE;
      gph_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      gph_q   <= gph_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    gph_d          = gph_q;
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    cmd_o.grad_sel = gph_q;
    case (state_q)
      dsrg_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (opcode_i == dsrg_pkg::OP_SESSION) begin
            gph_d   = 1'b0;
            state_d = dsrg_pkg::ST_MUL;
          end
        end
      end
      dsrg_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = dsrg_pkg::ST_UPD;
      end
      dsrg_pkg::ST_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = dsrg_pkg::ST_DIV;
      end
      dsrg_pkg::ST_DIV: begin
        cmd_o.div_go = 1'b1;
        state_d      = dsrg_pkg::ST_WAIT;
      end
      dsrg_pkg::ST_WAIT: begin
        if (sts_i.div_done) begin
          if (!gph_q && sts_i.grad_en) begin
            cmd_o.j_clr = 1'b1;
            gph_d       = 1'b1;
            state_d     = dsrg_pkg::ST_GRD;
          end else begin
            state_d = dsrg_pkg::ST_EMIT;
          end
        end
      end
      dsrg_pkg::ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (!gph_q || sts_i.last_dim) begin
            state_d = dsrg_pkg::ST_IDLE;
          end else begin
            cmd_o.j_inc = 1'b1;
            state_d     = dsrg_pkg::ST_GRD;
          end
        end
      end
      dsrg_pkg::ST_GRD: begin
        state_d = dsrg_pkg::ST_MUL;
      end
      default: begin
        state_d = dsrg_pkg::ST_IDLE;
      end
    endcase
  end

  `DSRG_ASSERT_IMP(a_done_in_wait, sts_i.div_done, state_q == dsrg_pkg::ST_WAIT, "divide done outside wait")
  `DSRG_ASSERT(a_session_busy, (in_valid_i && in_ready_o && opcode_i == dsrg_pkg::OP_SESSION) |=> !in_ready_o, "ready after session beat")
  `DSRG_ASSERT(a_rate_only_done, (state_q == dsrg_pkg::ST_EMIT && sts_i.out_free && !gph_q) |=> state_q == dsrg_pkg::ST_IDLE, "rate beat did not end session")

endmodule

>>> src/decayed_session_rate_gradient_top.sv
// Top level of the decayed session rate gradient block.
`timescale 1ns / 1ps
// Load and restart beats are taken in the idle state. With gradient mode off a session
// gives one rate result; with gradient mode on it gives one result per embedding
// dimension. The session length is set by the 32-step radix-2 divider that every rate
// and gradient element goes through in turn, after a multiply state and a sum-update
// state. The output register lets the next beat be taken while the last result waits.
module decayed_session_rate_gradient_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         opcode_i,
  input  logic [7:0]         project_index_i,
  input  logic [3:0]         element_index_i,
  input  logic signed [31:0] load_value_i,
  input  logic [15:0]        task_count_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [16:0]        cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] rate_o,
  output logic               has_gradient_o,
  output logic [3:0]         gradient_index_o,
  output logic signed [31:0] gradient_o,
  output logic               last_o
);

  dsrg_pkg::cmd_t cmd;
  dsrg_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  dsrg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (opcode_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dsrg_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .opcode_i         (opcode_i),
    .project_index_i  (project_index_i),
    .element_index_i  (element_index_i),
    .load_value_i     (load_value_i),
    .task_count_i     (task_count_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .rate_o           (rate_o),
    .has_gradient_o   (has_gradient_o),
    .gradient_index_o (gradient_index_o),
    .gradient_o       (gradient_o),
    .last_o           (last_o)
  );

endmodule

>>> bench/dsrg_rate_checker.sv
// Checker for the decayed session rate gradient block: predicts results and compares beats.
`timescale 1ns / 1ps
module dsrg_rate_checker
  import dsrg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [1:0]         opcode_i,
  input  logic [7:0]         project_index_i,
  input  logic [3:0]         element_index_i,
  input  logic signed [31:0] load_value_i,
  input  logic [15:0]        task_count_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [16:0]        cfg_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [31:0] rate_i,
  input  logic               has_gradient_i,
  input  logic [3:0]         gradient_index_i,
  input  logic signed [31:0] gradient_i,
  input  logic               last_i,
  output int                 errors_o,
  output int                 pending_o
);

  localparam longint SAT47 = 64'h0000_7FFF_FFFF_FFFF;

  typedef struct {
    logic [31:0] rate;
    logic        has_grad;
    logic [3:0]  grad_idx;
    logic [31:0] grad;
    logic        last;
  } rate_beat_t;

  rate_beat_t         rate_q[$];
  logic signed [31:0] inter_tbl[PROJECTS];
  logic signed [31:0] emb_tbl[EMB_DEPTH];
  longint             wtd_sum;
  longint             wgt_sum;
  longint             grad_sum[MAX_DIM];
  logic [7:0]         own_prj;
  logic [16:0]        decay;
  logic [15:0]        foreign_w;
  logic               grad_en;
  logic [4:0]         dims_cfg;

  function automatic longint clamp47(longint v);
    if (v > SAT47) return SAT47;
    if (v < -SAT47) return -SAT47;
    return v;
  endfunction

  function automatic longint decayed(longint v, longint unsigned f);
    longint unsigned m;
    longint unsigned p;
    m = (v < 0) ? longint'(-v) : longint'(v);
    p = (m * f) >> 16;
    return (v < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint weighted_term(longint unsigned wt, logic signed [31:0] val);
    longint unsigned m;
    longint unsigned p;
    longint sv;
    sv = val;
    m = (sv < 0) ? longint'(-sv) : longint'(sv);
    p = (wt * m) >> 8;
    return (sv < 0) ? -longint'(p) : longint'(p);
  endfunction

  function automatic logic [31:0] sat_quot(longint num, longint unsigned den);
    longint unsigned m;
    longint unsigned q;
    if (den == 0) begin
      if (num == 0) return 32'h0;
      return (num < 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    m = (num < 0) ? longint'(-num) : longint'(num);
    q = (m << 16) / (den * 5);
    if (num < 0) return (q > 64'h8000_0000) ? 32'h8000_0000 : 32'(-longint'(q));
    return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    errors_o++;
  endtask

  task automatic predict_session();
    longint unsigned f;
    longint unsigned w;
    longint unsigned wt;
    int              dims;
    logic [31:0]     rate;
    rate_beat_t      b;
    f    = (decay > 17'd65536) ? 65536 : decay;
    w    = (project_index_i == own_prj) ? 256 : foreign_w;
    wt   = w * task_count_i;
    wtd_sum = clamp47(decayed(wtd_sum, f) + weighted_term(wt, inter_tbl[project_index_i]));
    wgt_sum = clamp47(decayed(wgt_sum, f) + longint'(w << 8));
    rate = sat_quot(wtd_sum, wgt_sum);
    if (!grad_en) begin
      b = '{rate, 1'b0, 4'd0, 32'd0, 1'b1};
      rate_q.push_back(b);
      return;
    end
    dims = (dims_cfg == 0) ? 1 : ((dims_cfg > MAX_DIM) ? MAX_DIM : dims_cfg);
    for (int j = 0; j < dims; j++) begin
      grad_sum[j] = clamp47(decayed(grad_sum[j], f) +
                            weighted_term(wt, emb_tbl[project_index_i * MAX_DIM + j]));
      b = '{rate, 1'b1, 4'(j), sat_quot(grad_sum[j], wgt_sum), j + 1 == dims};
      rate_q.push_back(b);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rate_beat_t b;
    if (!rst_ni) begin
      rate_q.delete();
      wtd_sum   = 64'd10 << 16;
      wgt_sum   = 64'd10 << 16;
      foreach (grad_sum[j]) grad_sum[j] = 0;
      own_prj   = 8'd0;
      decay     = 17'd65536;
      foreign_w = 16'd256;
      grad_en   = 1'b0;
      dims_cfg  = 5'd16;
      errors_o  = 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (rate_q.size() == 0) begin
          report("unexpected beat rate", rate_i, 32'h0);
        end else begin
          b = rate_q.pop_front();
          if (rate_i !== b.rate) report("rate", rate_i, b.rate);
          if (has_gradient_i !== b.has_grad) report("has_gradient", has_gradient_i, b.has_grad);
          if (gradient_index_i !== b.grad_idx)
            report("gradient_index", gradient_index_i, b.grad_idx);
          if (gradient_i !== b.grad) report("gradient", gradient_i, b.grad);
          if (last_i !== b.last) report("last", last_i, b.last);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_OWN:     own_prj   = cfg_data_i[7:0];
          CFG_DECAY:   decay     = cfg_data_i;
          CFG_FOREIGN: foreign_w = cfg_data_i[15:0];
          CFG_GRAD:    grad_en   = cfg_data_i[0];
          CFG_DIMS:    dims_cfg  = cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        case (op_e'(opcode_i))
          OP_LOAD_INT: inter_tbl[project_index_i] = load_value_i;
          OP_LOAD_EMB: emb_tbl[project_index_i * MAX_DIM + element_index_i] = load_value_i;
          OP_RESTART: begin
            wtd_sum = 64'd10 << 16;
            wgt_sum = 64'd10 << 16;
            foreach (grad_sum[j]) grad_sum[j] = 0;
          end
          default: predict_session();
        endcase
      end
      pending_o <= rate_q.size();
    end
  end

endmodule

>>> bench/tb_decayed_session_rate_gradient_top.sv
// Testbench top: drives sessions, table loads and register writes into the block.
`timescale 1ns / 1ps
module tb_decayed_session_rate_gradient_top;
  import dsrg_pkg::*;

  localparam int        LIMIT    = 3000000;
  localparam logic [2:0] CFG_NONE = 3'd7;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         opcode;
  logic [7:0]         project_index;
  logic [3:0]         element_index;
  logic signed [31:0] load_value;
  logic [15:0]        task_count;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [16:0]        cfg_data;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] rate;
  logic               has_gradient;
  logic [3:0]         gradient_index;
  logic signed [31:0] gradient;
  logic               last;
  int                 errors;
  int                 pending;
  int                 cycles;
  int                 in_gap_pct;
  int                 out_gap_pct;
  logic               hold_go;
  logic               hold_seen;
  int                 stall_left;
  bit                 inter_ok[PROJECTS];
  bit [15:0]          emb_ok[PROJECTS];
  logic [7:0]         ready_rows[$];

  decayed_session_rate_gradient_top i_dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .opcode_i(opcode), .project_index_i(project_index), .element_index_i(element_index),
    .load_value_i(load_value), .task_count_i(task_count),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .rate_o(rate), .has_gradient_o(has_gradient), .gradient_index_o(gradient_index),
    .gradient_o(gradient), .last_o(last)
  );

  dsrg_rate_checker i_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .opcode_i(opcode), .project_index_i(project_index), .element_index_i(element_index),
    .load_value_i(load_value), .task_count_i(task_count),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .rate_i(rate), .has_gradient_i(has_gradient), .gradient_index_i(gradient_index),
    .gradient_i(gradient), .last_i(last),
    .errors_o(errors), .pending_o(pending)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: random backpressure, plus one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
      hold_seen  <= 1'b0;
    end else if (hold_go && !hold_seen) begin
      hold_seen  <= 1'b1;
      stall_left <= 3000;
      out_ready  <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= out_gap_pct);
    end
  end

  task automatic send_beat(op_e op, logic [7:0] p, logic [3:0] e, logic [31:0] v,
                           logic [15:0] t);
    if (in_gap_pct != 0 && $urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid      <= 1'b1;
    opcode        <= op;
    project_index <= p;
    element_index <= e;
    load_value    <= v;
    task_count    <= t;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    if (op == OP_LOAD_INT || op == OP_LOAD_EMB) begin
      if (op == OP_LOAD_INT) inter_ok[p] = 1'b1;
      else emb_ok[p][e] = 1'b1;
      if (inter_ok[p] && emb_ok[p] == 16'hFFFF && !(p inside {ready_rows}))
        ready_rows.push_back(p);
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [16:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($urandom_range(1 << 20)) - 32'(1 << 19);
      2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_tasks();
    case ($urandom_range(4))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return $urandom_range(15);
      default: return $urandom_range(65535);
    endcase
  endfunction

  task automatic load_row(logic [7:0] p);
    send_beat(OP_LOAD_INT, p, 4'd0, pick_value(), 16'd0);
    for (int j = 0; j < MAX_DIM; j++) send_beat(OP_LOAD_EMB, p, 4'(j), pick_value(), 16'd0);
  endtask

  task automatic session(logic [7:0] p, logic [15:0] t);
    send_beat(OP_SESSION, p, 4'($urandom_range(15)), $urandom, t);
  endtask

  task automatic random_regs();
    logic [16:0] d;
    write_reg(CFG_OWN, $urandom_range(1) ? 17'(ready_rows[$urandom_range(ready_rows.size() - 1)])
                                          : 17'($urandom_range(255)));
    case ($urandom_range(4))
      0: d = 17'd0;
      1: d = 17'd65536;
      2: d = 17'h1FFFF;
      3: d = $urandom_range(40000, 65536);
      default: d = $urandom_range(17'h1FFFF);
    endcase
    write_reg(CFG_DECAY, d);
    case ($urandom_range(3))
      0: d = 17'd0;
      1: d = 17'hFFFF;
      2: d = 17'd256;
      default: d = $urandom_range(65535);
    endcase
    write_reg(CFG_FOREIGN, d);
    write_reg(CFG_GRAD, $urandom_range(1));
    case ($urandom_range(11))
      0: d = 17'd0;
      1: d = 17'd16;
      2: d = 17'd31;
      default: d = $urandom_range(1, 4);
    endcase
    write_reg(CFG_DIMS, d);
  endtask

  task automatic random_beats(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 68)
        session(ready_rows[$urandom_range(ready_rows.size() - 1)], pick_tasks());
      else if (r < 78)
        send_beat(OP_LOAD_INT, $urandom_range(255), 4'd0, pick_value(), 16'd0);
      else if (r < 88)
        send_beat(OP_LOAD_EMB, $urandom_range(255), $urandom_range(15), pick_value(), 16'd0);
      else if (r < 93)
        load_row($urandom_range(255));
      else
        send_beat(OP_RESTART, $urandom_range(255), $urandom_range(15), $urandom, $urandom);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cycles        = 0;
    in_valid      = 1'b0;
    opcode        = OP_SESSION;
    project_index = '0;
    element_index = '0;
    load_value    = '0;
    task_count    = '0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_OWN;
    cfg_data      = '0;
    hold_go       = 1'b0;
    in_gap_pct    = 0;
    out_gap_pct   = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    load_row(8'd0);
    load_row(8'd1);
    load_row(8'd128);
    load_row(8'd255);

    // directed: field extremes with reset settings
    send_beat(OP_LOAD_INT, 8'd128, 4'd0, 32'h8000_0000, 16'd0);
    send_beat(OP_LOAD_INT, 8'd255, 4'd0, 32'h7FFF_FFFF, 16'd0);
    send_beat(OP_LOAD_EMB, 8'd255, 4'd15, 32'h8000_0000, 16'd0);
    send_beat(OP_LOAD_EMB, 8'd128, 4'd0, 32'h7FFF_FFFF, 16'd0);
    session(8'd0, 16'd0);
    session(8'd0, 16'hFFFF);
    session(8'd255, 16'hFFFF);
    session(8'd128, 16'hFFFF);
    send_beat(OP_RESTART, 8'hFF, 4'hF, 32'hFFFF_FFFF, 16'hFFFF);
    session(8'd1, 16'd3);
    drain();
    // zero weight and zero decay factor: weight sum drops to zero
    write_reg(CFG_OWN, 17'd5);
    write_reg(CFG_DECAY, 17'd0);
    write_reg(CFG_FOREIGN, 17'd0);
    write_reg(CFG_GRAD, 17'd1);
    write_reg(CFG_DIMS, 17'd16);
    session(8'd1, 16'd7);
    session(8'd255, 16'hFFFF);
    drain();
    write_reg(CFG_DECAY, 17'h1FFFF);
    write_reg(CFG_FOREIGN, 17'hFFFF);
    write_reg(CFG_DIMS, 17'd0);
    write_reg(CFG_NONE, 17'h1FFFF);
    session(8'd255, 16'hFFFF);
    session(8'd128, 16'hFFFF);
    drain();
    write_reg(CFG_DIMS, 17'd31);
    write_reg(CFG_OWN, 17'd255);
    session(8'd255, 16'd100);
    send_beat(OP_RESTART, 8'd0, 4'd0, 32'd0, 16'd0);
    session(8'd0, 16'd1);
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      in_gap_pct  = (ph == 0) ? 36 : ((ph == 1) ? 48 : 0);
      out_gap_pct = (ph == 0) ? 48 : ((ph == 1) ? 36 : 0);
      for (int c = 0; c < 4; c++) begin
        random_regs();
        if (ph == 2 && c == 0) begin
          write_reg(CFG_GRAD, 17'd0);
          hold_go <= 1'b1;
        end
        random_beats(16);
        drain();
      end
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
